// ===== hw/rtl/binary_erosion_window_macros.svh =====
// Assertion macros for the checker file.
`ifndef BINARY_EROSION_WINDOW_MACROS_SVH
`define BINARY_EROSION_WINDOW_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define BEW_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that stays armed during reset.
`define BEW_ASSERT_NEXT_NR(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bew_pkg.sv =====
`timescale 1ns / 1ps
package bew_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_ELEMENT = 7;

  localparam int COL_W  = 10;                          // out_col field width
  localparam int ROW_W  = 10;                          // out_row field width
  localparam int CFG_W  = 11;                          // width, height, row band registers
  localparam int HALF_W = 2;
  localparam int HIST_W = MAX_ELEMENT - 1;
  localparam int WIN_W  = MAX_ELEMENT * MAX_ELEMENT;
  localparam int HALF_MAX = (MAX_ELEMENT - 1) / 2;

  localparam int APB_DW = 64;
  localparam int APB_AW = 6;
  localparam int REG_LSB = 3;                          // registers on 8-byte stride

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [WIN_W-1:0]  win_t;

  typedef enum logic [2:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_HALF_H,
    REG_HALF_W,
    REG_MASK,
    REG_ROW_FIRST,
    REG_ROW_LAST
  } reg_idx_t;

endpackage

// ===== hw/rtl/bew_in_if.sv =====
`timescale 1ns / 1ps
interface bew_in_if;
  import bew_pkg::*;

  logic valid;
  logic ready;
  logic pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== hw/rtl/bew_out_if.sv =====
`timescale 1ns / 1ps
interface bew_out_if;
  import bew_pkg::*;

  logic valid;
  logic ready;
  row_t out_row;
  col_t out_col;
  logic eroded;

  modport source (output valid, output out_row, output out_col, output eroded, input ready);
  modport sink   (input valid, input out_row, input out_col, input eroded, output ready);
endinterface

// ===== hw/rtl/bew_ram.sv =====
`timescale 1ns / 1ps
module bew_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hw/rtl/binary_erosion_window.sv =====
`timescale 1ns / 1ps
// Binary erosion over a raster-order pixel stream, window up to 7x7.
//
// in_ch  : one pixel per transaction (pixel, frame_start). frame_start marks
//          row 0, column 0 of a new image and resets the position counters.
// out_ch : one transaction per interior centre inside the row band, carrying
//          out_row, out_col and eroded. Centres that fall on the border emit
//          nothing, so out_ch carries fewer transactions than in_ch.
// APB    : seven registers on an 8-byte stride, 64-bit data; write while the
//          block is idle. Reads return the stored value.
//
// Throughput: one pixel per cycle unless out_ch stalls. The line-store RAM read
// (registered output) sets the first stage; window update and element match fill
// the second, whose result register drives out_ch.
// Reset: position counters, window and pipeline valid bits clear at once, the
// registers take their defaults. The line store is not cleared; interior
// centres only read entries written earlier in the same frame.
// Stall: with out_ch held off the result register keeps its transaction, the
// middle stage fills, and then in_ch.ready drops until out_ch takes one.
module binary_erosion_window (
  input  logic                       clk,
  input  logic                       rst_n,
  bew_in_if.sink                     in_ch,
  bew_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bew_pkg::APB_AW-1:0] paddr,
  input  logic [bew_pkg::APB_DW-1:0] pwdata,
  output logic [bew_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import bew_pkg::*;

  // ---------------------------------------------------------------- registers
  cfg_t  width_r, height_r, row_first_r, row_last_r;
  half_t half_h_r, half_w_r;
  win_t  mask_r;

  logic     cfg_wr;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_W'(MAX_WIDTH);
      height_r    <= CFG_W'(1024);
      half_h_r    <= HALF_W'(1);
      half_w_r    <= HALF_W'(1);
      mask_r      <= WIN_W'(511);
      row_first_r <= '0;
      row_last_r  <= CFG_W'(1024);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:     width_r     <= pwdata[CFG_W-1:0];
        REG_HEIGHT:    height_r    <= pwdata[CFG_W-1:0];
        REG_HALF_H:    half_h_r    <= pwdata[HALF_W-1:0];
        REG_HALF_W:    half_w_r    <= pwdata[HALF_W-1:0];
        REG_MASK:      mask_r      <= pwdata[WIN_W-1:0];
        REG_ROW_FIRST: row_first_r <= pwdata[CFG_W-1:0];
        REG_ROW_LAST:  row_last_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:     prdata = APB_DW'(width_r);
      REG_HEIGHT:    prdata = APB_DW'(height_r);
      REG_HALF_H:    prdata = APB_DW'(half_h_r);
      REG_HALF_W:    prdata = APB_DW'(half_w_r);
      REG_MASK:      prdata = APB_DW'(mask_r);
      REG_ROW_FIRST: prdata = APB_DW'(row_first_r);
      REG_ROW_LAST:  prdata = APB_DW'(row_last_r);
      default:       prdata = '0;
    endcase
  end

  // -------------------------------------------------------- effective config
  half_t hh, hw;
  cfg_t  w_eff;

  // Clamp the halves to what a MAX_ELEMENT window can hold.
  assign hh = (32'(half_h_r) > HALF_MAX) ? HALF_W'(HALF_MAX) : half_h_r;
  assign hw = (32'(half_w_r) > HALF_MAX) ? HALF_W'(HALF_MAX) : half_w_r;

  // Zero width behaves as one, oversize as the line-store depth.
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end
  end

  // Required window bits, indexed column age*7 + row age.
  win_t req;
  always_comb begin
    logic [5:0] idx;
    logic [2:0] er, ec;
    req = '0;
    for (int ca = 0; ca < MAX_ELEMENT; ca++) begin
      for (int ra = 0; ra < MAX_ELEMENT; ra++) begin
        er  = 3'({hh, 1'b0}) - 3'(ra);
        ec  = 3'({hw, 1'b0}) - 3'(ca);
        idx = 6'(er) * 6'(MAX_ELEMENT) + 6'(ec);
        if (3'(ca) <= 3'({hw, 1'b0}) && 3'(ra) <= 3'({hh, 1'b0})) begin
          req[ca*MAX_ELEMENT + ra] = mask_r[idx];
        end
      end
    end
  end

  // ------------------------------------------------------------ handshakes
  logic out_valid_r, s1_valid_r;
  logic out_adv, s1_adv, in_acc, s1_leave;

  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ch.ready = s1_adv;
  assign in_acc   = in_ch.valid && s1_adv;
  assign s1_leave = s1_valid_r && out_adv;

  // ------------------------------------------------- stage 0: position track
  col_t col_r, col_nxt, c_cur;
  row_t row_r, row_nxt, r_cur;
  cfg_t c_inc;

  always_comb begin
    c_cur = in_ch.frame_start ? '0 : col_r;
    r_cur = in_ch.frame_start ? '0 : row_r;
    if (CFG_W'(c_cur) >= w_eff) begin
      c_cur = '0;
    end
    c_inc   = CFG_W'(c_cur) + CFG_W'(1);
    col_nxt = c_inc[COL_W-1:0];
    row_nxt = r_cur;
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r_cur + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ----------------------------------------------------------- line store
  hist_t ram_rd, hist, byp_d_r;
  logic  byp_r;
  col_t  s1_c_r;
  row_t  s1_r_r;
  logic  s1_pix_r;
  logic [MAX_ELEMENT-1:0] colvec;

  bew_ram #(
    .WIDTH(HIST_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_leave),
    .wr_addr (s1_c_r),
    .wr_data (colvec[HIST_W-1:0]),
    .rd_en   (in_acc),
    .rd_addr (c_cur),
    .rd_data (ram_rd)
  );

  // Forward the column being written when the next pixel reads the same
  // entry (width of one).
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_r    <= s1_leave && (s1_c_r == c_cur);
      byp_d_r  <= colvec[HIST_W-1:0];
      s1_c_r   <= c_cur;
      s1_r_r   <= r_cur;
      s1_pix_r <= in_ch.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_acc;
    end
  end

  // ------------------------------------------- stage 1: window and matching
  win_t window_r, window_nxt;
  logic match, emit;
  logic [CFG_W:0] r_lo, r_hi, rf_max, rl_ext;

  assign hist       = byp_r ? byp_d_r : ram_rd;
  assign colvec     = {hist, s1_pix_r};
  assign window_nxt = {window_r[WIN_W-MAX_ELEMENT-1:0], colvec};
  assign match      = &(~req | window_nxt);

  // Centre (r-hh, c-hw) lies in the band when r >= max(row_first,hh)+hh and
  // r < min(row_last+hh, height); the column test reduces to c >= 2*hw.
  always_comb begin
    rf_max = (row_first_r > CFG_W'(hh)) ? {1'b0, row_first_r} : (CFG_W+1)'(hh);
    r_lo   = rf_max + (CFG_W+1)'(hh);
    rl_ext = {1'b0, row_last_r} + (CFG_W+1)'(hh);
    r_hi   = (rl_ext < {1'b0, height_r}) ? rl_ext : {1'b0, height_r};
    emit   = (s1_c_r >= COL_W'({hw, 1'b0}))
             && ((CFG_W+1)'(s1_r_r) >= r_lo)
             && ((CFG_W+1)'(s1_r_r) <  r_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_leave) begin
      window_r <= window_nxt;
    end
  end

  // -------------------------------------------------------- result register
  row_t out_row_r;
  col_t out_col_r;
  logic eroded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      out_row_r <= s1_r_r - ROW_W'(hh);
      out_col_r <= s1_c_r - COL_W'(hw);
      eroded_r  <= match;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.out_col = out_col_r;
  assign out_ch.eroded  = eroded_r;
endmodule

// ===== hw/rtl/bew_chk.sv =====
`timescale 1ns / 1ps
`include "binary_erosion_window_macros.svh"
module bew_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [bew_pkg::ROW_W-1:0] out_row,
  input logic [bew_pkg::COL_W-1:0] out_col,
  input logic                eroded
);
  import bew_pkg::*;

  // Stalled result holds.
  `BEW_ASSERT(a_hold, $past(out_valid && !out_ready) && $past(rst_n), out_valid && $stable(out_row) && $stable(out_col) && $stable(eroded), "stalled result changed")

  // Reset empties the result register.
  `BEW_ASSERT_NEXT_NR(a_rst, !rst_n, !out_valid, "result valid after reset")

  // An empty result register never back-pressures the input.
  `BEW_ASSERT(a_ready, !out_valid, in_ready, "input blocked with empty output")

  // A new result comes from an accepted pixel carried through the stage-1 and result registers.
  `BEW_ASSERT(a_src, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a source pixel")
endmodule

bind binary_erosion_window bew_chk u_bew_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.out_row),
  .out_col   (out_ch.out_col),
  .eroded    (out_ch.eroded)
);

// ===== dv/binary_erosion_window_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the streaming erosion window.
// Pixels go in as raster-order transactions. A cycle-free predictor works out each
// centre result when its pixel is accepted, and the result transactions are
// checked against it in order.
module binary_erosion_window_tb;
  import bew_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_LIMIT   = 2000;   // cycles without any transaction before giving up
  localparam int DRAIN_CYCLES = 6;      // covers the two-stage pipe plus margin
  localparam int RANDOM_ITEMS = 1200;
  localparam int BURST_MAX    = 19;
  localparam int ROW_BAND_TOP = 2047;   // largest value the row band registers hold

  typedef struct packed {
    row_t row;
    col_t col;
    logic eroded;
  } erosion_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bew_in_if  pix_if ();
  bew_out_if res_if ();

  binary_erosion_window u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_if),
    .out_ch  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and of the window state.
  cfg_t  width_reg;
  cfg_t  height_reg;
  half_t half_h_reg;
  half_t half_w_reg;
  win_t  mask_reg;
  cfg_t  row_first_reg;
  cfg_t  row_last_reg;
  hist_t col_history [MAX_WIDTH];
  win_t  window;
  int    next_row;
  int    next_col;

  erosion_t erosion_q [$];   // results still owed by the block, oldest first

  int mismatches    = 0;
  int idle_cycles   = 0;
  int items_sent    = 0;
  int in_gap_pct    = 0;     // chance per transaction of a sender gap burst
  int out_stall_pct = 0;     // chance per cycle of a receiver stall burst

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_predictor();
    width_reg     = cfg_t'(MAX_WIDTH);
    height_reg    = cfg_t'(1024);
    half_h_reg    = half_t'(1);
    half_w_reg    = half_t'(1);
    mask_reg      = win_t'(511);
    row_first_reg = '0;
    row_last_reg  = cfg_t'(1024);
    foreach (col_history[i]) col_history[i] = '0;
    window   = '0;
    next_row = 0;
    next_col = 0;
  endfunction

  // Every required element position must hold a set pixel. Window bit
  // (column age * 7 + row age) holds the pixel, age 0 being the newest.
  function automatic logic window_eroded(input int hh, input int hw);
    for (int er = 0; er <= 2 * hh; er++) begin
      for (int ec = 0; ec <= 2 * hw; ec++) begin
        if (mask_reg[er * MAX_ELEMENT + ec] &&
            !window[(2 * hw - ec) * MAX_ELEMENT + (2 * hh - er)]) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Advance the model by one accepted pixel and queue the centre result it
  // completes, if that centre is interior and inside the row band.
  function automatic void predict_pixel(input logic pix, input logic fs);
    int hh;
    int hw;
    int w;
    int r;
    int c;
    int cr;
    int cc;
    int rlo;
    int rhi;
    int first_row;
    int last_row;
    logic [MAX_ELEMENT-1:0] column;
    erosion_t res;

    hh = (half_h_reg > HALF_MAX) ? HALF_MAX : int'(half_h_reg);
    hw = (half_w_reg > HALF_MAX) ? HALF_MAX : int'(half_w_reg);
    // Clamp the width into the line store's range.
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;

    // frame_start snaps the position back to the top-left corner
    if (fs) begin
      r = 0;
      c = 0;
    end else begin
      r = next_row;
      c = next_col;
    end
    if (c >= w) c = 0;

    // Shift the new pixel into the column history and the window.
    column         = {col_history[c], pix};
    col_history[c] = column[HIST_W-1:0];
    window         = {window[WIN_W-MAX_ELEMENT-1:0], column};

    first_row = int'(row_first_reg);
    last_row  = int'(row_last_reg);
    cr  = r - hh;
    cc  = c - hw;
    rlo = (first_row > hh) ? first_row : hh;
    rhi = int'(height_reg) - hh;
    if (last_row < rhi) rhi = last_row;

    if (cc >= hw && cc < w - hw && cr >= rlo && cr < rhi) begin
      res.row    = row_t'(cr);
      res.col    = col_t'(cc);
      res.eroded = window_eroded(hh, hw);
      erosion_q.push_back(res);
    end

    // Row keeps counting past the image height, wrapping after row 1023, until the next frame start.
    c++;
    if (c >= w) begin
      c = 0;
      r = (r + 1) % 1024;
    end
    next_row = r;
    next_col = c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; mirror the value into the
  // predictor once the access completes.
  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_LSB;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WIDTH:     width_reg     = value[CFG_W-1:0];
      REG_HEIGHT:    height_reg    = value[CFG_W-1:0];
      REG_HALF_H:    half_h_reg    = value[HALF_W-1:0];
      REG_HALF_W:    half_w_reg    = value[HALF_W-1:0];
      REG_MASK:      mask_reg      = value[WIN_W-1:0];
      REG_ROW_FIRST: row_first_reg = value[CFG_W-1:0];
      REG_ROW_LAST:  row_last_reg  = value[CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Send one pixel transaction, with an optional gap burst in front of it.
  // Valid stays high afterwards; the next call or a drain decides its fate.
  task automatic send_pixel(input logic pix, input logic fs);
    int gap;
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, BURST_MAX);
      @(negedge clk);
      pix_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_if.valid       <= 1'b1;
    pix_if.pixel       <= pix;
    pix_if.frame_start <= fs;
    do @(posedge clk); while (!pix_if.ready);
    predict_pixel(pix, fs);
    items_sent++;
  endtask

  // Drop valid, wait until every owed result has been taken, then let the pipe
  // settle: trailing border pixels may still be in flight with no result.
  task automatic drain();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (erosion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program all seven registers; only ever done with the block idle.
  task automatic set_window(input cfg_t w, input cfg_t h, input half_t hh, input half_t hw,
                            input win_t mask, input cfg_t first_row, input cfg_t last_row);
    drain();
    cfg_write(REG_WIDTH,     w);
    cfg_write(REG_HEIGHT,    h);
    cfg_write(REG_HALF_H,    hh);
    cfg_write(REG_HALF_W,    hw);
    cfg_write(REG_MASK,      mask);
    cfg_write(REG_ROW_FIRST, first_row);
    cfg_write(REG_ROW_LAST,  last_row);
  endtask

  function automatic win_t random_mask();
    return win_t'({$urandom, $urandom});
  endfunction

  // One raster frame with frame_start on its first pixel. A noisy frame is
  // cut short, runs past its last row, or restarts part way through.
  task automatic run_frame(input int cols, input int rows, input int density, input bit noisy);
    int total;
    int stop_at;
    int restart_at;
    total      = cols * rows;
    stop_at    = total;
    restart_at = -1;
    if (noisy) begin
      case ($urandom_range(0, 2))
        0:       stop_at    = $urandom_range(1, total);
        1:       stop_at    = total + $urandom_range(1, cols + 2);
        default: restart_at = $urandom_range(1, total);
      endcase
    end
    for (int i = 0; i < stop_at; i++) begin
      send_pixel($urandom_range(0, 99) < density, i == 0 || i == restart_at);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values untouched: full-width image, 3x3 window, mask 511. Three rows
  // give one complete row of centres across columns 1 to 1022.
  task automatic test_default_config();
    in_gap_pct    = 8;
    out_stall_pct = 8;
    run_frame(MAX_WIDTH, 3, 90, 1'b0);
  endtask

  // Hand-made frames: a single hole hits just one centre, and an empty element
  // erodes to 1 even over a blank image. In the first frame, unused mask bits are all set too.
  task automatic test_directed_corners();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_window(4, 4, 1, 1, '1, 0, ROW_BAND_TOP);
    for (int i = 0; i < 16; i++) begin
      send_pixel(i != 15, i == 0);
    end
    set_window(3, 3, 1, 1, '0, 0, ROW_BAND_TOP);
    for (int i = 0; i < 9; i++) begin
      send_pixel(1'b0, i == 0);
    end
  endtask

  // Heights and row bands that leave nothing to produce, then a narrow band.
  task automatic test_degenerate_rows();
    in_gap_pct    = 10;
    out_stall_pct = 10;
    set_window(5, 0, 1, 1, '1, 0, ROW_BAND_TOP);    // zero height
    run_frame(5, 4, 100, 1'b0);
    set_window(5, 2, 1, 1, '1, 0, ROW_BAND_TOP);    // too short for the element
    run_frame(5, 4, 100, 1'b0);
    set_window(5, 6, 1, 1, '1, 4, 2);               // band inverted
    run_frame(5, 6, 100, 1'b0);
    set_window(5, 6, 0, 2, random_mask(), 3, 5);    // band narrower than image
    run_frame(5, 6, 80, 1'b0);
  endtask

  // Width register above the line store: taken as the full 1024 columns.
  task automatic test_wide_row();
    in_gap_pct    = 5;
    out_stall_pct = 5;
    set_window(cfg_t'(ROW_BAND_TOP), 1, 0, 3, random_mask(), 0, 1);
    run_frame(MAX_WIDTH, 1, 95, 1'b0);
  endtask

  // Zero width reads as one column. Run past row 1023 to see the row wrap.
  task automatic test_tall_column();
    in_gap_pct    = 5;
    out_stall_pct = 5;
    set_window(0, cfg_t'(ROW_BAND_TOP), 0, 0, random_mask(), 1020, cfg_t'(ROW_BAND_TOP));
    run_frame(1, 1030, 50, 1'b0);
  endtask

  // Random frames: every element size, random masks, row bands and heights,
  // and a share of broken frames.
  task automatic test_random_frames();
    int    target;
    int    cols;
    int    rows;
    int    density;
    half_t hh;
    half_t hw;
    cfg_t  w_reg;
    cfg_t  h_reg;
    cfg_t  first_row;
    cfg_t  last_row;
    win_t  mask;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(2, 25);
        out_stall_pct = $urandom_range(2, 25);
      end
      hh   = half_t'($urandom_range(0, HALF_MAX));
      hw   = half_t'($urandom_range(0, HALF_MAX));
      cols = $urandom_range(2 * hw + 1, 2 * hw + 10);
      rows = $urandom_range(2 * hh + 1, 2 * hh + 8);
      w_reg = cfg_t'(cols);
      if ($urandom_range(0, 15) == 0) begin
        w_reg = '0;
        cols  = 1;
      end
      h_reg = ($urandom_range(0, 5) == 0) ? cfg_t'($urandom_range(0, rows + 2)) : cfg_t'(rows);
      case ($urandom_range(0, 3))
        0, 1: begin
          first_row = '0;
          last_row  = cfg_t'(ROW_BAND_TOP);
        end
        2: begin
          first_row = '0;
          last_row  = h_reg;
        end
        default: begin
          first_row = cfg_t'($urandom_range(0, rows));
          last_row  = cfg_t'($urandom_range(0, rows + 1));
        end
      endcase
      case ($urandom_range(0, 3))
        0:       mask = '1;
        1:       mask = random_mask();
        2:       mask = '0;
        default: mask = random_mask() & random_mask();
      endcase
      case ($urandom_range(0, 3))
        0:       density = 50;
        1:       density = 85;
        2:       density = 97;
        default: density = 100;
      endcase
      set_window(w_reg, h_reg, hh, hw, mask, first_row, last_row);
      run_frame(cols, rows, density, $urandom_range(0, 4) == 0);
    end
  endtask

  // Back-to-back frames with no idling at all on either side.
  task automatic test_steady_stream();
    set_window(12, 8, 1, 2, random_mask() | random_mask(), 0, cfg_t'(ROW_BAND_TOP));
    in_gap_pct    = 0;
    out_stall_pct = 0;
    run_frame(12, 8, 97, 1'b0);
    run_frame(12, 8, 100, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel       <= 1'b0;
    pix_if.frame_start <= 1'b0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_directed_corners();
    test_degenerate_rows();
    test_wide_row();
    test_tall_column();
    test_random_frames();
    test_steady_stream();

    drain();
    if (mismatches == 0 && erosion_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: hold ready low in random bursts, otherwise take every result.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, BURST_MAX) - 1) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest owed result, field by field.
  always @(posedge clk) begin : check_results
    erosion_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (erosion_q.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d eroded %0b", $time,
                 res_if.out_row, res_if.out_col, res_if.eroded);
        mismatches++;
      end else begin
        want = erosion_q.pop_front();
        if (res_if.out_row !== want.row) begin
          $display("%0t: out_row expected %0d, got %0d", $time, want.row, res_if.out_row);
          mismatches++;
        end
        if (res_if.out_col !== want.col) begin
          $display("%0t: out_col expected %0d, got %0d", $time, want.col, res_if.out_col);
          mismatches++;
        end
        if (res_if.eroded !== want.eroded) begin
          $display("%0t: eroded at (%0d,%0d) expected %0b, got %0b", $time,
                   want.row, want.col, want.eroded, res_if.eroded);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transaction on any port restarts the count.
  always @(posedge clk) begin
    if (!rst_n || psel || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bew_pkg.sv
hw/rtl/bew_in_if.sv
hw/rtl/bew_out_if.sv
hw/rtl/bew_ram.sv
hw/rtl/binary_erosion_window.sv
hw/rtl/bew_chk.sv
dv/binary_erosion_window_tb.sv
